// ===== rtl/usrx_pkg.sv =====
// shared types, constants and helpers for the serial receive fifo register port
`default_nettype none

package usrx_pkg;

  // receive ring geometry
  localparam int unsigned FifoDepth = 1024;
  localparam int unsigned PtrW      = $clog2(FifoDepth);

  // item kinds
  typedef enum logic [1:0] {
    OP_READ  = 2'd0,
    OP_WRITE = 2'd1,
    OP_RX    = 2'd2,
    OP_POLL  = 2'd3
  } opcode_e;

  // bus register select
  localparam logic PortData   = 1'b0;
  localparam logic PortStatus = 1'b1;

  // configuration register index
  localparam logic RegLink = 1'b0;

  // status and data constants
  localparam logic [7:0] StatusBase  = 8'h80;
  localparam logic [7:0] StatusTxRdy = 8'h05;
  localparam logic [7:0] StatusRxRdy = 8'h02;
  localparam logic [7:0] EmptyRead   = 8'hFF;

  typedef logic [PtrW-1:0] ptr_t;

  // requests to the fifo
  typedef struct packed {
    logic       push;
    logic       pop;
    logic [7:0] wdata;
  } fifo_ctrl_t;

  // fifo flags
  typedef struct packed {
    logic empty;
    logic full;
  } fifo_stat_t;

  // ring pointer advance with wrap
  function automatic ptr_t ring_next(ptr_t p);
    ring_next = (p == PtrW'(FifoDepth - 1)) ? '0 : p + PtrW'(1);
  endfunction

endpackage

`default_nettype wire

// ===== rtl/usart_rx_fifo_register_port_core.sv =====
// serial port register block with receive ring fifo: top level
//
//  channel   direction  handshake                 payload
//  input     in         in_valid_i / in_ready_o   opcode, port_select, write_value, rx_byte,
//                                                 tx_idle
//  result    out        out_valid_o / out_ready_i read_data, tx_valid, tx_byte, irq_request,
//                                                 rx_overflow
//  config    in         apb psel/penable/pwrite   link_enabled at byte address 0
//
// one item per cycle while results are taken; a result passes the middle stage
// and then the output register; the middle stage waits for the registered read of the fifo memory for data pops.
// pointers and interrupt state update in the transfer cycle, so back-to-back
// items see each other's effects. reset clears pointers, interrupt flag,
// link enable and all valid flags; memory contents are not cleared.
// a stalled result holds the output register and, once the middle stage is
// also full, input ready drops.
`default_nettype none

module usart_rx_fifo_register_port_core (
  input  wire         clk_i,
  input  wire         rst_ni,
  // input items
  input  wire         in_valid_i,
  output logic        in_ready_o,
  input  wire  [1:0]  opcode_i,
  input  wire         port_select_i,
  input  wire  [7:0]  write_value_i,
  input  wire  [7:0]  rx_byte_i,
  input  wire         tx_idle_i,
  // result items
  output logic        out_valid_o,
  input  wire         out_ready_i,
  output logic [7:0]  read_data_o,
  output logic        tx_valid_o,
  output logic [7:0]  tx_byte_o,
  output logic        irq_request_o,
  output logic        rx_overflow_o,
  // configuration
  input  wire         psel,
  input  wire         penable,
  input  wire         pwrite,
  input  wire  [2:0]  paddr,
  input  wire  [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic link_q;
  logic irq_pending_q, irq_pending_d;

  usrx_pkg::fifo_ctrl_t fifo_ctrl;
  usrx_pkg::fifo_stat_t fifo_stat;
  logic [7:0]           ram_rdata;

  logic       in_fire, stg_adv, out_fire;
  logic       stg_valid_q, stg_use_ram_q, stg_txv_q, stg_irq_q, stg_ovf_q;
  logic [7:0] stg_rd_q, stg_txb_q;
  logic       out_valid_q, out_txv_q, out_irq_q, out_ovf_q;
  logic [7:0] out_rd_q, out_txb_q;

  // decoded result of the accepted item
  logic       dec_use_ram, dec_txv, dec_irq, dec_ovf;
  logic [7:0] dec_rd, dec_txb;
  usrx_pkg::opcode_e op;

  // configuration port
  assign pready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      link_q <= 1'b0;
    end else if (psel && penable && pwrite && pready && (paddr[2] == usrx_pkg::RegLink)) begin
      link_q <= pwdata[0];
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr[2] == usrx_pkg::RegLink) begin
      prdata = {31'b0, link_q};
    end
  end

  // handshake
  assign out_fire   = out_valid_q && out_ready_i;
  assign stg_adv    = stg_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !stg_valid_q || stg_adv;
  assign in_fire    = in_valid_i && in_ready_o;

  // item decode, fifo requests and interrupt state
  always_comb begin
    op            = usrx_pkg::opcode_e'(opcode_i);
    dec_use_ram   = 1'b0;
    dec_rd        = '0;
    dec_txv       = 1'b0;
    dec_txb       = '0;
    dec_irq       = 1'b0;
    dec_ovf       = 1'b0;
    fifo_ctrl     = '{push: 1'b0, pop: 1'b0, wdata: rx_byte_i};
    irq_pending_d = irq_pending_q;
    if (in_fire && link_q) begin
      case (op)
        usrx_pkg::OP_READ: begin
          if (port_select_i == usrx_pkg::PortData) begin
            irq_pending_d = 1'b0;
            if (!fifo_stat.empty) begin
              fifo_ctrl.pop = 1'b1;
              dec_use_ram   = 1'b1;
            end else begin
              dec_rd = usrx_pkg::EmptyRead;
            end
          end else begin
            dec_rd = usrx_pkg::StatusBase
                   | (tx_idle_i ? usrx_pkg::StatusTxRdy : 8'h00)
                   | (!fifo_stat.empty ? usrx_pkg::StatusRxRdy : 8'h00);
          end
        end
        usrx_pkg::OP_WRITE: begin
          if (port_select_i == usrx_pkg::PortData) begin
            dec_txv = 1'b1;
            dec_txb = write_value_i;
          end
        end
        usrx_pkg::OP_RX: begin
          if (fifo_stat.full) begin
            dec_ovf = 1'b1;
          end else begin
            fifo_ctrl.push = 1'b1;
          end
        end
        default: begin
          if (!fifo_stat.empty && !irq_pending_q) begin
            dec_irq       = 1'b1;
            irq_pending_d = 1'b1;
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      irq_pending_q <= 1'b0;
    end else begin
      irq_pending_q <= irq_pending_d;
    end
  end

  usrx_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctrl_i  (fifo_ctrl),
    .stat_o  (fifo_stat),
    .rdata_o (ram_rdata)
  );

  // middle stage: waits for the memory read
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stg_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      stg_valid_q <= in_fire;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      stg_use_ram_q <= dec_use_ram;
      stg_rd_q      <= dec_rd;
      stg_txv_q     <= dec_txv;
      stg_txb_q     <= dec_txb;
      stg_irq_q     <= dec_irq;
      stg_ovf_q     <= dec_ovf;
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (stg_adv) begin
      out_valid_q <= 1'b1;
    end else if (out_fire) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (stg_adv) begin
      out_rd_q  <= stg_use_ram_q ? ram_rdata : stg_rd_q;
      out_txv_q <= stg_txv_q;
      out_txb_q <= stg_txb_q;
      out_irq_q <= stg_irq_q;
      out_ovf_q <= stg_ovf_q;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign read_data_o   = out_rd_q;
  assign tx_valid_o    = out_txv_q;
  assign tx_byte_o     = out_txb_q;
  assign irq_request_o = out_irq_q;
  assign rx_overflow_o = out_ovf_q;

  // checks
  a_no_pop_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fifo_ctrl.pop |-> !fifo_stat.empty)
    else $error("pop issued on empty fifo");

  a_no_push_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fifo_ctrl.push |-> !fifo_stat.full)
    else $error("push issued on full fifo");

  a_stage_loaded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |=> stg_valid_q)
    else $error("accepted item not held in middle stage");

  a_stage_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (stg_valid_q && !stg_adv) |=> stg_valid_q && $stable(stg_use_ram_q))
    else $error("stalled middle stage lost its item");

endmodule

`default_nettype wire

// ===== rtl/usrx_fifo.sv =====
// receive ring fifo: byte memory with registered read and its two pointers
`default_nettype none

module usrx_fifo (
  input  wire                   clk_i,
  input  wire                   rst_ni,
  input  wire usrx_pkg::fifo_ctrl_t ctrl_i,
  output usrx_pkg::fifo_stat_t  stat_o,
  output logic [7:0]            rdata_o
);

  logic [7:0]     mem [usrx_pkg::FifoDepth];
  usrx_pkg::ptr_t wptr_q, wptr_d;
  usrx_pkg::ptr_t rptr_q, rptr_d;
  logic [7:0]     rdata_q;

  // flags from the pointers
  always_comb begin
    stat_o.empty = (wptr_q == rptr_q);
    stat_o.full  = (usrx_pkg::ring_next(wptr_q) == rptr_q);
  end

  // pointer updates
  always_comb begin
    wptr_d = ctrl_i.push ? usrx_pkg::ring_next(wptr_q) : wptr_q;
    rptr_d = ctrl_i.pop  ? usrx_pkg::ring_next(rptr_q) : rptr_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
    end
  end

  // memory write port and registered read port
  always_ff @(posedge clk_i) begin
    if (ctrl_i.push) begin
      mem[wptr_q] <= ctrl_i.wdata;
    end
    if (ctrl_i.pop) begin
      rdata_q <= mem[rptr_q];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire
